// ----- hw/rtl/gb_pkg.sv -----
// Shared types and constants for the 5x5 binomial blur.
// Used by the stream interfaces, the window stage and the top level.
package gb_pkg;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 12;
  localparam int LINE_W     = 32;
  localparam int CSUM_W     = 12;
  localparam int HSUM_W     = 16;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_HEIGHT    = 4096;
  localparam int MIN_SIZE      = 5;

  localparam logic [CFG_DATA_W-1:0] RESET_WIDTH  = CFG_DATA_W'(640);
  localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = CFG_DATA_W'(480);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic             center_valid;
    logic             interior;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             frame_last;
  } gb_meta_t;

endpackage

// ----- hw/rtl/gb_pixel_if.sv -----
// Input pixel channel: valid/ready handshake with one 8-bit pixel.
// Depends on gb_pkg.
interface gb_pixel_if import gb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// ----- hw/rtl/gb_result_if.sv -----
// Result channel: valid/ready handshake carrying one blurred centre.
// Depends on gb_pkg.
interface gb_result_if import gb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             center_valid;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic [PIX_W-1:0] blurred;
  logic             frame_last;

  modport source (output valid, output center_valid, output out_row, output out_col,
                  output blurred, output frame_last, input ready);
  modport sink   (input valid, input center_valid, input out_row, input out_col,
                  input blurred, input frame_last, output ready);
endinterface

// ----- hw/rtl/gaussian_blur_5x5.sv -----
// Top level of the 5x5 binomial blur: counters, line store and pipeline.
// Depends on gb_pkg, gb_pixel_if, gb_result_if, gb_ram and gb_window.
//
//  channel   dir  handshake          payload
//  pix_i     in   valid/ready        pixel
//  res_o     out  valid/ready        center_valid, out_row, out_col, blurred, frame_last
//  cfg       in   cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// One pixel per cycle sustained while res_o is not stalled.
// Stages: line-store read, column sum into the window, horizontal sum into the result register.
// The line store is read in the accept cycle and written back as the item leaves
// the read stage; consecutive requests never share a column address.
// Reset clears counters, window and stage valids; the line store is not cleared.
// A stalled result holds the pipeline stage by stage; bubbles close up.
module gaussian_blur_5x5 import gb_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  gb_pixel_if.sink              pix_i,
  gb_result_if.source           res_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;
  localparam int HW = ROW_W + 1;

  logic [CFG_DATA_W-1:0] frame_width_q;
  logic [CFG_DATA_W-1:0] frame_height_q;
  logic [CW-1:0]         col_q, col_d;
  logic [ROW_W-1:0]      row_q, row_d;

  logic                  s1_valid_q;
  logic [CW-1:0]         s1_col_q;
  logic [PIX_W-1:0]      s1_pix_q;
  gb_meta_t              s1_meta_q;
  gb_meta_t              meta_d;

  logic [SW-1:0]         fw_ext, w_eff, w_m1, col_ext, col_m2;
  logic [HW-1:0]         h_eff, h_m1, row_ext;
  logic                  end_col, end_row;
  logic                  accept, win_ready, move12;
  logic [LINE_W-1:0]     rdata;
  logic [CSUM_W-1:0]     col_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= RESET_WIDTH;
      frame_height_q <= RESET_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    fw_ext = SW'(frame_width_q);
    if (fw_ext < SW'(MIN_SIZE)) begin
      w_eff = SW'(MIN_SIZE);
    end else if (fw_ext > SW'(MAX_WIDTH)) begin
      w_eff = SW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    if (frame_height_q < CFG_DATA_W'(MIN_SIZE)) begin
      h_eff = HW'(MIN_SIZE);
    end else if (frame_height_q > CFG_DATA_W'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height_q);
    end
  end

  assign w_m1    = w_eff - SW'(1);
  assign h_m1    = h_eff - HW'(1);
  assign col_ext = SW'(col_q);
  assign row_ext = HW'(row_q);
  assign col_m2  = col_ext - SW'(2);
  assign end_col = col_ext >= w_m1;
  assign end_row = row_ext >= h_m1;

  always_comb begin
    meta_d.center_valid = (row_q >= ROW_W'(2)) && (col_ext >= SW'(2));
    meta_d.interior     = (row_q >= ROW_W'(4)) && (col_ext >= SW'(4));
    meta_d.out_row      = meta_d.center_valid ? row_q - ROW_W'(2) : '0;
    meta_d.out_col      = meta_d.center_valid ? col_m2[COL_W-1:0] : '0;
    meta_d.frame_last   = end_col && end_row;
    col_d = col_q;
    row_d = row_q;
    if (end_col) begin
      col_d = '0;
      row_d = end_row ? '0 : row_q + ROW_W'(1);
    end else begin
      col_d = col_q + CW'(1);
    end
  end

  assign pix_i.ready = !s1_valid_q || win_ready;
  assign accept      = pix_i.valid && pix_i.ready;
  assign move12      = s1_valid_q && win_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (pix_i.ready) begin
        s1_valid_q <= pix_i.valid;
      end
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q  <= col_q;
      s1_pix_q  <= pix_i.pixel;
      s1_meta_q <= meta_d;
    end
  end

  gb_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (move12),
    .waddr_i (s1_col_q),
    .wdata_i ({rdata[LINE_W-PIX_W-1:0], s1_pix_q}),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rdata)
  );

  assign col_sum = CSUM_W'(rdata[31:24])
                 + (CSUM_W'(rdata[23:16]) << 2)
                 + (CSUM_W'(rdata[15:8]) << 2) + (CSUM_W'(rdata[15:8]) << 1)
                 + (CSUM_W'(rdata[7:0]) << 2)
                 + CSUM_W'(s1_pix_q);

  gb_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s1_valid_q),
    .in_ready_o (win_ready),
    .col_sum_i  (col_sum),
    .meta_i     (s1_meta_q),
    .res        (res_o)
  );

`ifndef SYNTHESIS
  a_no_same_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move12 && accept) |-> (s1_col_q != col_q))
    else $error("line store read and write collide on one column");

  a_stage1_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s1_valid_q) |-> move12)
    else $error("request accepted over an occupied read stage");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (SW'(col_q) < SW'(MAX_WIDTH)))
    else $error("column counter beyond line store depth");
`endif

endmodule

// ----- hw/rtl/gb_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module gb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/gb_window.sv -----
// Column-sum window and horizontal filter with the result register.
// Depends on gb_pkg and gb_result_if.
module gb_window import gb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CSUM_W-1:0]  col_sum_i,
  input  gb_meta_t           meta_i,
  gb_result_if.source        res
);

  logic [CSUM_W-1:0] win_q [5];
  gb_meta_t          s2_meta_q;
  logic              s2_valid_q;
  logic              out_valid_q;
  logic              out_cv_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;
  logic [PIX_W-1:0]  out_pix_q;
  logic              out_last_q;

  logic              out_ready;
  logic              move_in;
  logic              move_out;
  logic [HSUM_W-1:0] hsum;

  assign out_ready  = !out_valid_q || res.ready;
  assign in_ready_o = !s2_valid_q || out_ready;
  assign move_in    = in_valid_i && in_ready_o;
  assign move_out   = s2_valid_q && out_ready;

  assign hsum = HSUM_W'(win_q[0]) + (HSUM_W'(win_q[1]) << 2)
              + (HSUM_W'(win_q[2]) << 2) + (HSUM_W'(win_q[2]) << 1)
              + (HSUM_W'(win_q[3]) << 2) + HSUM_W'(win_q[4]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (in_ready_o) begin
        s2_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= s2_valid_q;
      end
      if (move_in) begin
        for (int i = 0; i < 4; i++) begin
          win_q[i] <= win_q[i+1];
        end
        win_q[4] <= col_sum_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move_in) begin
      s2_meta_q <= meta_i;
    end
    if (move_out) begin
      out_cv_q   <= s2_meta_q.center_valid;
      out_row_q  <= s2_meta_q.out_row;
      out_col_q  <= s2_meta_q.out_col;
      out_pix_q  <= s2_meta_q.interior ? hsum[HSUM_W-1:8] : '0;
      out_last_q <= s2_meta_q.frame_last;
    end
  end

  assign res.valid        = out_valid_q;
  assign res.center_valid = out_cv_q;
  assign res.out_row      = out_row_q;
  assign res.out_col      = out_col_q;
  assign res.blurred      = out_pix_q;
  assign res.frame_last   = out_last_q;

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for gaussian_blur_5x5: drives pixel frames and checks every
// blurred centre against an in-bench line-store and window predictor.
// Depends on gb_pkg, gb_pixel_if, gb_result_if and the gaussian_blur_5x5 RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gb_pkg::*;

  localparam int          SETTLE_CYCLES = 6;
  localparam int          TAIL_CYCLES   = 8;
  localparam int unsigned BINOMIAL [5]  = '{1, 4, 6, 4, 1};

  typedef enum logic [1:0] {
    REQ_PIXEL,
    REQ_CONFIG,
    REQ_DRAIN
  } req_kind_e;

  typedef enum logic [2:0] {
    FILL_RANDOM,
    FILL_BLACK,
    FILL_WHITE,
    FILL_CHECKER,
    FILL_SPIKES
  } fill_e;

  typedef struct packed {
    req_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [PIX_W-1:0]      pixel;
    logic                  calm;
  } stim_req_t;

  typedef struct packed {
    logic             center_valid;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic [PIX_W-1:0] blurred;
    logic             frame_last;
  } blur_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  gb_pixel_if  pix_if ();
  gb_result_if res_if ();

  gaussian_blur_5x5 u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_if),
    .res_o       (res_if)
  );

  stim_req_t    stim_queue [$];
  blur_result_t blur_expected [$];
  int           mismatch_count = 0;
  int           stim_items     = 0;

  logic                  pix_taken = 1'b0;
  logic                  res_taken = 1'b0;
  int unsigned           send_gap = 0;
  int unsigned           stall_left = 0;
  int unsigned           quiet_left = 0;
  int                    settle_count = 0;
  logic                  bulk_mode = 1'b0;

  // predictor state
  logic [LINE_W-1:0]     line_mem [MAX_WIDTH_DEF];
  logic [PIX_W-1:0]      win [5][5];
  int unsigned           col_cnt;
  int unsigned           row_cnt;
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;

  function automatic int unsigned clamp_size(logic [CFG_DATA_W-1:0] v, int unsigned hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned pick_gap(logic calm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if (roll < 2) quiet_left = $urandom_range(30, 150);
    if (roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (calm || roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic blur_result_t blur_predict(logic [PIX_W-1:0] pix);
    int unsigned       w;
    int unsigned       h;
    int unsigned       r;
    int unsigned       c;
    int unsigned       idx;
    int unsigned       sum;
    logic [LINE_W-1:0] word;
    logic              end_col;
    logic              end_row;
    blur_result_t      res;
    w       = clamp_size(width_reg, MAX_WIDTH_DEF);
    h       = clamp_size(height_reg, MAX_HEIGHT);
    r       = row_cnt;
    c       = col_cnt;
    idx     = c % MAX_WIDTH_DEF;
    word    = line_mem[idx];
    end_col = (c >= w - 1);
    end_row = (r >= h - 1);

    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 4; j++)
        win[i][j] = win[i][j+1];
    win[0][4] = word[31:24];
    win[1][4] = word[23:16];
    win[2][4] = word[15:8];
    win[3][4] = word[7:0];
    win[4][4] = pix;
    line_mem[idx] = {word[23:0], pix};

    sum = 0;
    if (r >= 4 && c >= 4) begin
      for (int i = 0; i < 5; i++)
        for (int j = 0; j < 5; j++)
          sum += win[i][j] * BINOMIAL[i] * BINOMIAL[j];
      sum = sum >> 8;
      if (sum > 255) sum = 255;
    end

    res.center_valid = (r >= 2 && c >= 2);
    res.out_row      = res.center_valid ? ROW_W'(r - 2) : '0;
    res.out_col      = res.center_valid ? COL_W'(c - 2) : '0;
    res.blurred      = res.center_valid ? PIX_W'(sum) : '0;
    res.frame_last   = end_col && end_row;

    if (end_col) begin
      col_cnt = 0;
      row_cnt = end_row ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
    return res;
  endfunction

  task automatic add_frame(input logic [CFG_DATA_W-1:0] w_val, input logic [CFG_DATA_W-1:0] h_val,
                           input fill_e fill, input logic calm, input int drain_at);
    int        w;
    int        h;
    stim_req_t req;
    w = clamp_size(w_val, MAX_WIDTH_DEF);
    h = clamp_size(h_val, MAX_HEIGHT);
    req = '{kind: REQ_CONFIG, idx: CFG_FRAME_WIDTH, data: w_val, pixel: '0, calm: calm};
    stim_queue.push_back(req);
    req.idx  = CFG_FRAME_HEIGHT;
    req.data = h_val;
    stim_queue.push_back(req);
    for (int n = 0; n < w * h; n++) begin
      if (n == drain_at) begin
        req.kind = REQ_DRAIN;
        stim_queue.push_back(req);
      end
      req.kind = REQ_PIXEL;
      case (fill)
        FILL_BLACK:   req.pixel = '0;
        FILL_WHITE:   req.pixel = '1;
        FILL_CHECKER: req.pixel = (((n / w) + (n % w)) % 2) ? '1 : '0;
        FILL_SPIKES:  req.pixel = $urandom_range(0, 1) ? '1 : '0;
        default:      req.pixel = PIX_W'($urandom_range(0, 255));
      endcase
      stim_queue.push_back(req);
    end
    stim_items += w * h;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // sender: hold a request until taken, then advance through the queue
  always @(negedge clk_i) begin
    logic                  drv_valid;
    logic [PIX_W-1:0]      drv_pixel;
    logic                  drv_we;
    logic [CFG_IDX_W-1:0]  drv_idx;
    logic [CFG_DATA_W-1:0] drv_data;
    drv_valid = pix_if.valid;
    drv_pixel = pix_if.pixel;
    drv_we    = 1'b0;
    drv_idx   = cfg_idx_i;
    drv_data  = cfg_wdata_i;
    if (rst_ni && !(pix_if.valid && !pix_taken)) begin
      drv_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (stim_queue.size() > 0) begin
        case (stim_queue[0].kind)
          REQ_PIXEL: begin
            drv_valid = 1'b1;
            drv_pixel = stim_queue[0].pixel;
            bulk_mode = stim_queue[0].calm;
            send_gap  = pick_gap(stim_queue[0].calm);
            void'(stim_queue.pop_front());
          end
          REQ_CONFIG: begin
            if (blur_expected.size() == 0) settle_count++;
            else settle_count = 0;
            if (settle_count >= SETTLE_CYCLES) begin
              drv_we   = 1'b1;
              drv_idx  = stim_queue[0].idx;
              drv_data = stim_queue[0].data;
              void'(stim_queue.pop_front());
            end
          end
          REQ_DRAIN: begin
            if (blur_expected.size() == 0) void'(stim_queue.pop_front());
          end
          default: void'(stim_queue.pop_front());
        endcase
      end
    end
    pix_if.valid <= drv_valid;
    pix_if.pixel <= drv_pixel;
    cfg_we_i     <= drv_we;
    cfg_idx_i    <= drv_idx;
    cfg_wdata_i  <= drv_data;
  end

  // receiver: stall for a random spell after each result taken
  always @(negedge clk_i) begin
    logic drv_ready;
    drv_ready = 1'b1;
    if (stall_left > 0) begin
      stall_left--;
      drv_ready = 1'b0;
    end else if (res_taken) begin
      stall_left = pick_gap(bulk_mode);
      if (stall_left > 0) begin
        stall_left--;
        drv_ready = 1'b0;
      end
    end
    res_if.ready <= drv_ready;
  end

  always @(posedge clk_i) begin
    blur_result_t got;
    blur_result_t want;
    pix_taken <= rst_ni && pix_if.valid && pix_if.ready;
    res_taken <= rst_ni && res_if.valid && res_if.ready;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_FRAME_WIDTH) width_reg = cfg_wdata_i;
        else height_reg = cfg_wdata_i;
      end
      if (pix_if.valid && pix_if.ready) blur_expected.push_back(blur_predict(pix_if.pixel));
      if (res_if.valid && res_if.ready) begin
        got.center_valid = res_if.center_valid;
        got.out_row      = res_if.out_row;
        got.out_col      = res_if.out_col;
        got.blurred      = res_if.blurred;
        got.frame_last   = res_if.frame_last;
        if (blur_expected.size() == 0) begin
          $error("result with no request pending: row %0d col %0d", got.out_row, got.out_col);
          mismatch_count++;
        end else begin
          want = blur_expected.pop_front();
          if (got.center_valid !== want.center_valid) begin
            $error("center_valid: expected %0d, got %0d", want.center_valid, got.center_valid);
            mismatch_count++;
          end
          if (got.out_row !== want.out_row) begin
            $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
            mismatch_count++;
          end
          if (got.out_col !== want.out_col) begin
            $error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
            mismatch_count++;
          end
          if (got.blurred !== want.blurred) begin
            $error("blurred: expected %0d, got %0d", want.blurred, got.blurred);
            mismatch_count++;
          end
          if (got.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0d, got %0d", want.frame_last, got.frame_last);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned roll;
    int          w_pick;
    int          h_pick;
    fill_e       fill;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    res_if.ready = 1'b1;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_FRAME_WIDTH;
    cfg_wdata_i  = '0;
    rst_ni       = 1'b0;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win[i, j]) win[i][j] = '0;
    col_cnt    = 0;
    row_cnt    = 0;
    width_reg  = RESET_WIDTH;
    height_reg = RESET_HEIGHT;

    // sizes below the minimum, saturating pixels, pause mid-frame
    add_frame(13'd0, 13'd4, FILL_WHITE, 1'b0, 12);

    while (stim_items < 600) begin
      roll   = $urandom_range(0, 99);
      w_pick = (roll < 10) ? $urandom_range(0, 4) : $urandom_range(5, 24);
      roll   = $urandom_range(0, 99);
      h_pick = (roll < 10) ? $urandom_range(0, 4) : $urandom_range(5, 10);
      roll   = $urandom_range(0, 99);
      if (roll < 70) fill = FILL_RANDOM;
      else if (roll < 76) fill = FILL_BLACK;
      else if (roll < 82) fill = FILL_WHITE;
      else if (roll < 91) fill = FILL_CHECKER;
      else fill = FILL_SPIKES;
      add_frame(CFG_DATA_W'(w_pick), CFG_DATA_W'(h_pick), fill, 1'b0,
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24) : -1);
    end

    // finish on a small frame with short gaps only
    add_frame(13'd7, 13'd6, FILL_CHECKER, 1'b1, -1);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (stim_queue.size() != 0 || pix_if.valid || blur_expected.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && blur_expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
